@@ hw/rtl/first_fit_contiguous_allocator_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Shared macros for the concurrent checks of the slot allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CONTIGUOUS_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_CONTIGUOUS_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFCA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define FFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFCA_ASSERT(lbl, prop, msg)
`define FFCA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/ffca_pkg.sv @@
// ----------------------------------------------------------------------------
// Allocator package
// Sizes, codes and shared types of the first-fit slot allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int LEN_W      = 11;
    localparam int BASE_W     = 10;
    localparam int STATUS_W   = 2;
    localparam int SPAN_W     = LEN_W + 1;
    localparam int WORD_W     = 8;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORD_COUNT = SLOT_COUNT / WORD_W;
    localparam int WADDR_W    = $clog2(WORD_COUNT);
    localparam int RUN_W      = SLOT_W + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RUN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

    typedef struct packed {
        logic [RUN_W-1:0]  run;
        logic [SLOT_W-1:0] start;
    } t_run_state;

    typedef struct packed {
        logic       found;
        t_run_state st;
    } t_scan_res;

endpackage

@@ hw/rtl/ffca_if.sv @@
// ----------------------------------------------------------------------------
// Allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffca_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [ffca_pkg::LEN_W-1:0]  run_length;
    logic [ffca_pkg::BASE_W-1:0] free_base;

    modport source (output valid, output opcode, output run_length, output free_base,
                    input ready);
    modport sink (input valid, input opcode, input run_length, input free_base,
                  output ready);
endinterface

interface ffca_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffca_pkg::BASE_W-1:0]   granted_base;
    logic [ffca_pkg::STATUS_W-1:0] status;

    modport source (output valid, output granted_base, output status, input ready);
    modport sink (input valid, input granted_base, input status, output ready);
endinterface

@@ hw/rtl/ffca_map_mem.sv @@
// ----------------------------------------------------------------------------
// Occupancy map memory
// Word-wide used-bit store with one read and one write port and per-word
// valid bits, so that a word never written reads as all free.
// ----------------------------------------------------------------------------
module ffca_map_mem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [ffca_pkg::WADDR_W-1:0]   i_rd_addr,
    output logic [ffca_pkg::WORD_W-1:0]    o_rd_data,
    input  logic                           i_wr_en,
    input  logic [ffca_pkg::WADDR_W-1:0]   i_wr_addr,
    input  logic [ffca_pkg::WORD_W-1:0]    i_wr_data
);

    logic [ffca_pkg::WORD_W-1:0]     r_mem [ffca_pkg::WORD_COUNT];
    logic [ffca_pkg::WORD_COUNT-1:0] r_vld;
    logic [ffca_pkg::WORD_W-1:0]     r_rd_word;
    logic                            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_word : '0;

endmodule

@@ hw/rtl/ffca_word_scan.sv @@
// ----------------------------------------------------------------------------
// Word run scanner
// Extends the current free run over one map word and reports the first
// point at which the run reaches the requested length.
// ----------------------------------------------------------------------------
module ffca_word_scan (
    input  logic [ffca_pkg::WORD_W-1:0]  i_word,
    input  logic [ffca_pkg::WADDR_W-1:0] i_word_addr,
    input  ffca_pkg::t_run_state         i_run,
    input  logic [ffca_pkg::LEN_W-1:0]   i_len,
    output ffca_pkg::t_scan_res          o_res
);

    localparam int RUN_W  = ffca_pkg::RUN_W;
    localparam int SPAN_W = ffca_pkg::SPAN_W;
    localparam int BIT_W  = ffca_pkg::BIT_W;

    always_comb begin
        logic                        found;
        logic [RUN_W-1:0]            run;
        logic [ffca_pkg::SLOT_W-1:0] start;
        logic [ffca_pkg::SLOT_W-1:0] slot;
        found = 1'b0;
        run   = i_run.run;
        start = i_run.start;
        slot  = '0;
        for (int j = 0; j < ffca_pkg::WORD_W; j++) begin
            slot = {i_word_addr, BIT_W'(j)};
            if (!found) begin
                if (!i_word[j]) begin
                    if (run == '0) begin
                        start = slot;
                    end
                    run = run + RUN_W'(1);
                    if (SPAN_W'(run) == SPAN_W'(i_len)) begin
                        found = 1'b1;
                    end
                end else begin
                    run = '0;
                end
            end
        end
        o_res.found    = found;
        o_res.st.run   = run;
        o_res.st.start = start;
    end

endmodule

@@ hw/rtl/first_fit_contiguous_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// First-fit contiguous allocator
// Allocates and frees runs of consecutive slots in a 1024-slot occupancy map.
// ----------------------------------------------------------------------------
// The map is held as 128 words of 8 slots in a memory with one read and one
// write port, and every request that reaches the map walks it one word per
// cycle. An allocate request scans from word 0 (at most 128 words) until a
// free run of the requested length is complete, then rewrites the words the
// run covers; a free request rewrites only the words its range covers, and a
// zero-length or rejected request does not touch the map. One request is in
// work at a time; a finished response waits in an output register without
// holding the next request, but a further result waits in S_DONE until the
// register has been taken.
module first_fit_contiguous_allocator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffca_req_if.sink   i_req,
    ffca_rsp_if.source o_rsp
);

`include "first_fit_contiguous_allocator_unit_defines.svh"

    localparam int SLOT_W  = ffca_pkg::SLOT_W;
    localparam int LEN_W   = ffca_pkg::LEN_W;
    localparam int BASE_W  = ffca_pkg::BASE_W;
    localparam int SPAN_W  = ffca_pkg::SPAN_W;
    localparam int WORD_W  = ffca_pkg::WORD_W;
    localparam int BIT_W   = ffca_pkg::BIT_W;
    localparam int WADDR_W = ffca_pkg::WADDR_W;
    localparam int RUN_W   = ffca_pkg::RUN_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(ffca_pkg::WORD_COUNT - 1);

    logic [1:0]                    r_state, n_state;
    logic                          r_set, n_set;
    logic [LEN_W-1:0]              r_len, n_len;
    logic [SPAN_W-1:0]             r_lo, n_lo;
    logic [SPAN_W-1:0]             r_hi, n_hi;
    logic [WADDR_W-1:0]            r_rd_addr, n_rd_addr;
    logic [WADDR_W-1:0]            r_last, n_last;
    logic                          r_issue, n_issue;
    logic                          r_pend, n_pend;
    logic [WADDR_W-1:0]            r_proc_addr, n_proc_addr;
    ffca_pkg::t_run_state          r_run, n_run;
    logic [BASE_W-1:0]             r_res_base, n_res_base;
    logic [ffca_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic                          r_rsp_valid, n_rsp_valid;
    logic [BASE_W-1:0]             r_rsp_base, n_rsp_base;
    logic [ffca_pkg::STATUS_W-1:0] r_rsp_status, n_rsp_status;

    logic                  w_rd_en;
    logic [WORD_W-1:0]     w_rd_data;
    logic                  w_wr_en;
    logic [WORD_W-1:0]     w_wr_data;
    logic [WORD_W-1:0]     w_mask;
    logic                  w_accept;
    logic [SPAN_W-1:0]     w_free_sum;
    logic [SPAN_W-1:0]     w_free_last;
    logic [SPAN_W-1:0]     w_alloc_lo;
    logic [SPAN_W-1:0]     w_alloc_hi;
    logic [SPAN_W-1:0]     w_alloc_last;
    ffca_pkg::t_scan_res   w_scan;

    ffca_map_mem u_map_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_proc_addr),
        .i_wr_data (w_wr_data)
    );

    ffca_word_scan u_word_scan (
        .i_word      (w_rd_data),
        .i_word_addr (r_proc_addr),
        .i_run       (r_run),
        .i_len       (r_len),
        .o_res       (w_scan)
    );

    always_comb begin
        logic [SPAN_W-1:0] slot;
        slot = '0;
        for (int j = 0; j < WORD_W; j++) begin
            slot      = SPAN_W'({r_proc_addr, BIT_W'(j)});
            w_mask[j] = (slot >= r_lo) && (slot < r_hi);
        end
    end

    assign w_wr_data    = r_set ? (w_rd_data | w_mask) : (w_rd_data & ~w_mask);
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_free_sum   = SPAN_W'(i_req.free_base) + SPAN_W'(i_req.run_length);
    assign w_free_last  = w_free_sum - SPAN_W'(1);
    assign w_alloc_lo   = SPAN_W'(w_scan.st.start);
    assign w_alloc_hi   = w_alloc_lo + SPAN_W'(r_len);
    assign w_alloc_last = w_alloc_hi - SPAN_W'(1);
    assign w_rd_en      = ((r_state == S_SCAN) || (r_state == S_APPLY)) && r_issue;

    always_comb begin
        n_state      = r_state;
        n_set        = r_set;
        n_len        = r_len;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_rd_addr    = r_rd_addr;
        n_last       = r_last;
        n_issue      = r_issue;
        n_pend       = w_rd_en;
        n_proc_addr  = r_rd_addr;
        n_run        = r_run;
        n_res_base   = r_res_base;
        n_res_status = r_res_status;
        n_rsp_valid  = r_rsp_valid;
        n_rsp_base   = r_rsp_base;
        n_rsp_status = r_rsp_status;
        w_wr_en      = 1'b0;

        if (w_rd_en) begin
            if (r_rd_addr == r_last) begin
                n_issue = 1'b0;
            end else begin
                n_rd_addr = r_rd_addr + WADDR_W'(1);
            end
        end

        if (o_rsp.valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_len        = i_req.run_length;
                    n_set        = (i_req.opcode == ffca_pkg::OP_ALLOC);
                    n_run        = '0;
                    n_pend       = 1'b0;
                    n_res_base   = '0;
                    n_res_status = ffca_pkg::ST_OK;
                    if (i_req.opcode == ffca_pkg::OP_FREE) begin
                        if (w_free_sum > SPAN_W'(ffca_pkg::SLOT_COUNT)) begin
                            n_res_status = ffca_pkg::ST_BAD;
                            n_state      = S_DONE;
                        end else if (i_req.run_length == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_lo      = SPAN_W'(i_req.free_base);
                            n_hi      = w_free_sum;
                            n_rd_addr = n_lo[SLOT_W-1:BIT_W];
                            n_last    = w_free_last[SLOT_W-1:BIT_W];
                            n_issue   = 1'b1;
                            n_state   = S_APPLY;
                        end
                    end else if (i_req.run_length == '0) begin
                        n_res_status = ffca_pkg::ST_BAD;
                        n_state      = S_DONE;
                    end else begin
                        n_rd_addr = '0;
                        n_last    = LAST_WORD;
                        n_issue   = 1'b1;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (w_scan.found) begin
                        n_lo         = w_alloc_lo;
                        n_hi         = w_alloc_hi;
                        n_rd_addr    = w_alloc_lo[SLOT_W-1:BIT_W];
                        n_last       = w_alloc_last[SLOT_W-1:BIT_W];
                        n_issue      = 1'b1;
                        n_pend       = 1'b0;
                        n_res_base   = BASE_W'(w_scan.st.start);
                        n_res_status = ffca_pkg::ST_OK;
                        n_state      = S_APPLY;
                    end else if (r_proc_addr == LAST_WORD) begin
                        n_res_status = ffca_pkg::ST_NO_RUN;
                        n_issue      = 1'b0;
                        n_pend       = 1'b0;
                        n_state      = S_DONE;
                    end else begin
                        n_run = w_scan.st;
                    end
                end
            end
            S_APPLY: begin
                if (r_pend) begin
                    w_wr_en = 1'b1;
                    if (r_proc_addr == r_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_base   = r_res_base;
                    n_rsp_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set        <= n_set;
        r_len        <= n_len;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_rd_addr    <= n_rd_addr;
        r_last       <= n_last;
        r_proc_addr  <= n_proc_addr;
        r_run        <= n_run;
        r_res_base   <= n_res_base;
        r_res_status <= n_res_status;
        r_rsp_base   <= n_rsp_base;
        r_rsp_status <= n_rsp_status;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.granted_base = r_rsp_base;
    assign o_rsp.status       = r_rsp_status;

    `FFCA_ASSERT(a_apply_range, (r_state == S_APPLY) |-> (r_lo < r_hi), "Empty update range.")
    `FFCA_ASSERT(a_fail_base, (o_rsp.valid && o_rsp.status != ffca_pkg::ST_OK) |-> (o_rsp.granted_base == '0), "Failed response carries a base.")
    `FFCA_ASSERT_NEXT(a_accept_busy, i_req.valid && i_req.ready, r_state != S_IDLE, "Request accepted without work.")
    `FFCA_ASSERT(a_run_bound, (r_state == S_SCAN) |-> (r_run.run <= RUN_W'(ffca_pkg::SLOT_COUNT)), "Free run longer than the map.")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit allocator testbench
// Drives allocate and free requests into the slot allocator, predicts each
// response from its own copy of the occupancy map, and checks every response
// field in order, with random gaps on the request side and random stalls on
// the response side in all but the last phase.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOT_COUNT = ffca_pkg::SLOT_COUNT;
    localparam int LEN_W      = ffca_pkg::LEN_W;
    localparam int BASE_W     = ffca_pkg::BASE_W;
    localparam int STATUS_W   = ffca_pkg::STATUS_W;

    typedef struct packed {
        logic [BASE_W-1:0]   granted_base;
        logic [STATUS_W-1:0] status;
    } t_alloc_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ffca_req_if req_ch ();
    ffca_rsp_if rsp_ch ();

    first_fit_contiguous_allocator_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bit [SLOT_COUNT-1:0] slot_busy;
    t_alloc_result       pending_grants[$];
    int unsigned         live_base[$];
    int unsigned         live_len[$];
    int unsigned         fail_count = 0;
    int unsigned         stall_left = 0;
    bit                  idle_on = 1'b1;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("** first_fit_contiguous_allocator_unit: FAILED **");
        $finish;
    end

    function automatic t_alloc_result first_fit_outcome(input logic op,
                                                        input logic [LEN_W-1:0] len,
                                                        input logic [BASE_W-1:0] fb);
        t_alloc_result res;
        int unsigned   run;
        int unsigned   base;
        res.granted_base = '0;
        res.status       = ffca_pkg::ST_NO_RUN;
        run              = 0;
        if (op == ffca_pkg::OP_FREE) begin
            if (int'(fb) + int'(len) > SLOT_COUNT) begin
                res.status = ffca_pkg::ST_BAD;
            end else begin
                for (int k = 0; k < int'(len); k++) slot_busy[int'(fb) + k] = 1'b0;
                res.status = ffca_pkg::ST_OK;
            end
        end else if (len == '0) begin
            res.status = ffca_pkg::ST_BAD;
        end else begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (!slot_busy[i]) run++;
                else run = 0;
                if (run == 32'(len)) begin
                    base = 32'(i + 1 - int'(len));
                    for (int k = 0; k < int'(len); k++) slot_busy[base + k] = 1'b1;
                    res.granted_base = base[BASE_W-1:0];
                    res.status       = ffca_pkg::ST_OK;
                    break;
                end
            end
        end
        return res;
    endfunction

    // The request stays valid across back-to-back sends; a gap lowers it first.
    task automatic send_request(input logic op, input logic [LEN_W-1:0] len,
                                input logic [BASE_W-1:0] fb, output t_alloc_result res);
        res = first_fit_outcome(op, len, fb);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.run_length <= len;
        req_ch.free_base  <= fb;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_grants.insert(pending_grants.size(), res);
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected response: granted_base %0d, status %0d",
                       rsp_ch.granted_base, rsp_ch.status);
                fail_count++;
            end else begin
                want = pending_grants.pop_front();
                if (rsp_ch.granted_base !== want.granted_base) begin
                    $error("granted_base: expected %0d, actual %0d",
                           want.granted_base, rsp_ch.granted_base);
                    fail_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return LEN_W'($urandom_range(1, 16));
        if (r < 90) return LEN_W'($urandom_range(17, 128));
        if (r < 98) return LEN_W'($urandom_range(129, SLOT_COUNT));
        if (r == 98) return '0;
        return LEN_W'($urandom_range(SLOT_COUNT + 1, (1 << LEN_W) - 1));
    endfunction

    task automatic test_length_limits();
        t_alloc_result res;
        send_request(ffca_pkg::OP_ALLOC, 11'd0, 10'd0, res);
        send_request(ffca_pkg::OP_ALLOC, 11'd2047, 10'd1023, res);
        send_request(ffca_pkg::OP_ALLOC, 11'd1025, 10'd0, res);
        send_request(ffca_pkg::OP_ALLOC, 11'd1024, 10'd512, res);
        send_request(ffca_pkg::OP_ALLOC, 11'd1, 10'd0, res);
        send_request(ffca_pkg::OP_FREE, 11'd1024, 10'd0, res);
    endtask

    task automatic test_free_ranges();
        t_alloc_result res;
        send_request(ffca_pkg::OP_FREE, 11'd2, 10'd1023, res);
        send_request(ffca_pkg::OP_FREE, 11'd1, 10'd1023, res);
        send_request(ffca_pkg::OP_FREE, 11'd0, 10'd0, res);
        send_request(ffca_pkg::OP_FREE, 11'd2047, 10'd1023, res);
        send_request(ffca_pkg::OP_FREE, 11'd1025, 10'd0, res);
        send_request(ffca_pkg::OP_FREE, 11'd1023, 10'd1, res);
    endtask

    task automatic test_first_fit_holes();
        t_alloc_result res;
        send_request(ffca_pkg::OP_ALLOC, 11'd3, 10'd0, res);
        send_request(ffca_pkg::OP_ALLOC, 11'd5, 10'd0, res);
        send_request(ffca_pkg::OP_ALLOC, 11'd1, 10'd0, res);
        send_request(ffca_pkg::OP_FREE, 11'd5, 10'd3, res);
        send_request(ffca_pkg::OP_ALLOC, 11'd6, 10'd0, res);
        send_request(ffca_pkg::OP_ALLOC, 11'd5, 10'd0, res);
        send_request(ffca_pkg::OP_ALLOC, 11'd1009, 10'd0, res);
        send_request(ffca_pkg::OP_ALLOC, 11'd1, 10'd0, res);
        send_request(ffca_pkg::OP_FREE, 11'd1024, 10'd0, res);
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        t_alloc_result res;
        int unsigned   r;
        int unsigned   idx;
        int unsigned   off;
        int unsigned   len;
        logic          op;
        for (int n = 0; n < int'(n_items); n++) begin
            r = $urandom_range(0, 99);
            if (r >= 50 && r < 85 && live_base.size() != 0) begin
                idx = $urandom_range(0, live_base.size() - 1);
                off = 0;
                len = live_len[idx];
                if ($urandom_range(0, 7) == 0) begin
                    off = $urandom_range(0, len - 1);
                    len = $urandom_range(0, len - off);
                end
                send_request(ffca_pkg::OP_FREE, LEN_W'(len), BASE_W'(live_base[idx] + off),
                             res);
                live_base.delete(idx);
                live_len.delete(idx);
            end else if (r >= 85 && r < 88) begin
                send_request(ffca_pkg::OP_FREE, LEN_W'(SLOT_COUNT), 10'd0, res);
                live_base.delete();
                live_len.delete();
            end else if (r >= 88) begin
                op = 1'($urandom_range(0, 1));
                send_request(op, LEN_W'($urandom_range(0, (1 << LEN_W) - 1)),
                             BASE_W'($urandom_range(0, SLOT_COUNT - 1)), res);
            end else begin
                len = 32'(pick_length());
                send_request(ffca_pkg::OP_ALLOC, LEN_W'(len),
                             BASE_W'($urandom_range(0, SLOT_COUNT - 1)), res);
                if (res.status == ffca_pkg::ST_OK) begin
                    live_base.insert(live_base.size(), 32'(res.granted_base));
                    live_len.insert(live_len.size(), len);
                end
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = ffca_pkg::OP_ALLOC;
        req_ch.run_length = '0;
        req_ch.free_base  = '0;
        rsp_ch.ready      = 1'b0;
        slot_busy         = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_length_limits();
        test_free_ranges();
        test_first_fit_holes();
        test_random_traffic(700);
        drain_responses();
        test_random_traffic(600);
        drain_responses();
        idle_on = 1'b0;
        test_random_traffic(250);
        drain_responses();
        repeat (300) @(posedge i_clk);

        if (fail_count == 0 && pending_grants.size() == 0) begin
            $display("** first_fit_contiguous_allocator_unit: PASSED **");
        end else begin
            $display("** first_fit_contiguous_allocator_unit: FAILED **");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_if.sv
hw/rtl/ffca_map_mem.sv
hw/rtl/ffca_word_scan.sv
hw/rtl/first_fit_contiguous_allocator_unit.sv
tb/tb.sv
